// ----- rtl/arlrsf_pkg.sv -----
// Shared constants and register codes for the autoregressive log-return forecast block.
// Used by the log unit, the ratio stage, the tap cells and the top level. No dependencies.
`default_nettype none

package arlrsf_pkg;

	// Default length of the tap chain.
	localparam int TAPS_DEF = 6;
	// Number of coefficient registers; taps beyond these carry weight zero.
	localparam int NCOEF = 6;

	localparam int PRICE_W   = 32;
	localparam int LOG_INT_W = 5;
	localparam int LOG_FRAC  = 24;
	localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
	localparam int RATIO_W   = 24;
	localparam int COEF_W    = 24;
	localparam int TAPSEL_W  = 3;
	localparam int SUM_W     = 40;
	localparam int FRAC_OUT  = 20;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;

	// ln(2) in Q0.32.
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic signed [RATIO_W-1:0] RATIO_MAX = 24'sh7FFFFF;
	localparam logic signed [RATIO_W-1:0] RATIO_MIN = 24'sh800000;

	typedef enum logic [2:0] {
		REG_ACTIVE_TAPS = 3'd0,
		REG_COEF_TAP0   = 3'd1,
		REG_COEF_TAP1   = 3'd2,
		REG_COEF_TAP2   = 3'd3,
		REG_COEF_TAP3   = 3'd4,
		REG_COEF_TAP4   = 3'd5,
		REG_COEF_TAP5   = 3'd6
	} reg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/arlrsf_log2.sv -----
// Iterative log2 unit: five normalize steps, then 24 squaring steps, one per cycle.
// Result is log2(x) in unsigned Q5.24. Depends on arlrsf_pkg.
`default_nettype none

module arlrsf_log2 (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [arlrsf_pkg::PRICE_W-1:0]        x,
	output logic                                       done,
	output logic [arlrsf_pkg::LOG_W-1:0]               log_val
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQR
	} state_t;

	state_t                                  state_q;
	logic [4:0]                              cnt_q;
	logic [arlrsf_pkg::PRICE_W-1:0]          m_q;
	logic [arlrsf_pkg::LOG_INT_W-1:0]        e_q;
	logic [arlrsf_pkg::LOG_FRAC-1:0]         frac_q;
	logic                                    done_q;

	logic [5:0]                              sh;
	logic [63:0]                             sq;
	logic [32:0]                             sqh;
	logic                                    top_zero;
	logic                                    last_sqr;

	// Normalize by 16, 8, 4, 2, 1 bit positions in turn.
	assign sh       = 6'd16 >> cnt_q[2:0];
	assign top_zero = ((m_q >> (6'd32 - sh)) == '0);
	assign sq       = 64'(m_q) * 64'(m_q);
	assign sqh      = sq[63:31];
	assign last_sqr = (state_q == ST_SQR) && (cnt_q == 5'(arlrsf_pkg::LOG_FRAC - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= last_sqr;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_NORM;
						cnt_q   <= '0;
					end
				end
				ST_NORM: begin
					if (cnt_q == 5'd4) begin
						cnt_q   <= '0;
						state_q <= ST_SQR;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_SQR: begin
					if (last_sqr) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					// A zero price counts as one tick.
					m_q    <= (x == '0) ? 32'd1 : x;
					e_q    <= 5'd31;
					frac_q <= '0;
				end
			end
			ST_NORM: begin
				if (top_zero) begin
					m_q <= m_q << sh;
					e_q <= e_q - sh[4:0];
				end
			end
			ST_SQR: begin
				// A square at or above two yields a one bit and halves the mantissa.
				frac_q <= {frac_q[arlrsf_pkg::LOG_FRAC-2:0], sqh[32]};
				m_q    <= sqh[32] ? sqh[32:1] : sqh[31:0];
			end
			default: begin
				m_q <= m_q;
			end
		endcase
	end

	assign done    = done_q;
	assign log_val = {e_q, frac_q};

endmodule

`default_nettype wire

// ----- rtl/arlrsf_ratio.sv -----
// Log ratio unit: two log2 units in lockstep, then difference, scale by ln2, round, saturate.
// Gives ln(open/close) in signed Q4.20. Depends on arlrsf_pkg and arlrsf_log2.
`default_nettype none

module arlrsf_ratio (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [arlrsf_pkg::PRICE_W-1:0]        bar_open,
	input  wire logic [arlrsf_pkg::PRICE_W-1:0]        bar_close,
	output logic                                       ratio_vld,
	output logic signed [arlrsf_pkg::RATIO_W-1:0]      ratio
);

	localparam int LW = arlrsf_pkg::LOG_W;
	localparam int PW = LW + 32;

	logic                done_open;
	logic                done_close;
	logic [LW-1:0]       log_open;
	logic [LW-1:0]       log_close;

	logic signed [LW:0]  diff;
	logic                v_s1, v_s2, v_s3;
	logic                neg_s1, neg_s2;
	logic [LW-1:0]       mag_s1;
	logic [PW-1:0]       prod_s2;
	logic signed [arlrsf_pkg::RATIO_W-1:0] ratio_s3;

	logic [PW:0]         rnd;
	logic [PW-36:0]      r;

	arlrsf_log2 u_log_open (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.x       (bar_open),
		.done    (done_open),
		.log_val (log_open)
	);

	arlrsf_log2 u_log_close (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.x       (bar_close),
		.done    (done_close),
		.log_val (log_close)
	);

	assign diff = $signed({1'b0, log_open}) - $signed({1'b0, log_close});
	assign rnd  = {1'b0, prod_s2} + ((PW + 1)'(1) << 35);
	assign r    = rnd[PW:36];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= done_open && done_close;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= diff[LW];
		mag_s1  <= diff[LW] ? LW'(-diff) : LW'(diff);
		neg_s2  <= neg_s1;
		prod_s2 <= PW'(mag_s1) * PW'(arlrsf_pkg::LN2_Q32);
		if (neg_s2) begin
			ratio_s3 <= (r > (PW - 35)'(24'h800000)) ? arlrsf_pkg::RATIO_MIN
			                                         : arlrsf_pkg::RATIO_W'(-r);
		end else begin
			ratio_s3 <= (r > (PW - 35)'(24'h7FFFFF)) ? arlrsf_pkg::RATIO_MAX
			                                         : arlrsf_pkg::RATIO_W'(r);
		end
	end

	assign ratio_vld = v_s3;
	assign ratio     = ratio_s3;

endmodule

`default_nettype wire

// ----- rtl/arlrsf_tap_cell.sv -----
// One cell of the tap chain: holds one log ratio and adds its weighted term to the
// partial sum passing through. Depends on arlrsf_pkg.
`default_nettype none

module arlrsf_tap_cell #(
	parameter int ACC_W = 51
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	input  wire logic                                  en,
	input  wire logic signed [arlrsf_pkg::COEF_W-1:0]  coef,
	input  wire logic signed [arlrsf_pkg::RATIO_W-1:0] ratio_in,
	output logic signed [arlrsf_pkg::RATIO_W-1:0]      ratio_out,
	input  wire logic                                  sum_vld_in,
	input  wire logic signed [ACC_W-1:0]               sum_in,
	output logic                                       sum_vld_out,
	output logic signed [ACC_W-1:0]                    sum_out
);

	localparam int PROD_W = arlrsf_pkg::COEF_W + arlrsf_pkg::RATIO_W;

	logic signed [arlrsf_pkg::RATIO_W-1:0] ratio_q;
	logic                                  vld_q;
	logic signed [ACC_W-1:0]               sum_q;
	logic signed [PROD_W-1:0]              prod;

	assign prod = coef * ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (push) begin
				ratio_q <= ratio_in;
			end
			vld_q <= sum_vld_in;
		end
	end

	// A cell outside the lookback passes the sum through unchanged.
	always_ff @(posedge clk) begin
		sum_q <= en ? (sum_in + ACC_W'(prod)) : sum_in;
	end

	assign ratio_out   = ratio_q;
	assign sum_vld_out = vld_q;
	assign sum_out     = sum_q;

endmodule

`default_nettype wire

// ----- rtl/ar_log_return_sign_forecast.sv -----
// Top level of the autoregressive log-return sign forecast: APB registers, stream
// handshake, control sequencer and the tap chain. Depends on arlrsf_pkg, arlrsf_ratio,
// arlrsf_tap_cell.
//
// Each accepted item is one price bar. The block works on one item at a time: the prices
// are loaded into the log units, normalized and squared bit by bit into both log2 values,
// the difference is scaled by ln2, rounded and saturated, the new ratio is pushed into the
// tap chain, the partial sum then walks the chain one cell per cycle, and the sum is
// captured and the rounded value loaded into the output register. The input is ready again
// in the cycle after the output register is loaded, so a new bar is taken only once the
// last one has reached the output register. A result that is not taken waits in the output
// register while the next bar is worked on, and only holds that bar back once it is ready
// for the output register itself. The ratio history and bar count are cleared by reset;
// the user must write configuration only while the block is idle, and the block itself
// does not enforce it.
`default_nettype none

module ar_log_return_sign_forecast #(
	parameter int TAPS = arlrsf_pkg::TAPS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// APB configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [arlrsf_pkg::APB_AW-1:0]     paddr,
	input  wire logic [arlrsf_pkg::APB_DW-1:0]     pwdata,
	output logic [arlrsf_pkg::APB_DW-1:0]          prdata,
	output logic                                   pready,
	// Input bars
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [31:0] bar_open, [63:32] bar_close
	input  wire logic [63:0]                       s_axis_tdata,
	// Results
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [39:0] forecast_sum, [40] go_long, [47:41] zero
	output logic [47:0]                            m_axis_tdata,
	// [0] history_ready
	output logic [0:0]                             m_axis_tuser
);

	localparam int RW    = arlrsf_pkg::RATIO_W;
	localparam int CW    = arlrsf_pkg::COEF_W;
	localparam int ACC_W = 2 * RW + $clog2(TAPS);
	localparam int CNT_W = $clog2(TAPS + 1);
	localparam int Q_W   = ACC_W + 1 - arlrsf_pkg::FRAC_OUT;
	localparam int SW    = arlrsf_pkg::SUM_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOG,
		ST_SUM,
		ST_WRITE
	} state_t;

	// Configuration registers
	logic [arlrsf_pkg::TAPSEL_W-1:0] taps_q;
	logic signed [CW-1:0]            coef_q [arlrsf_pkg::NCOEF];
	logic [2:0]                      reg_idx;
	logic                            cfg_wr;

	// Control
	state_t                          state_q;
	logic                            sum_start_q;
	logic [CNT_W-1:0]                bars_seen_q;
	logic [CNT_W-1:0]                taps_eff;
	logic                            in_accept;
	logic                            out_load;

	// Ratio unit
	logic                            ratio_vld;
	logic signed [RW-1:0]            ratio;

	// Tap chain
	logic signed [RW-1:0]            ratio_w [TAPS+1];
	logic signed [ACC_W-1:0]         sum_w   [TAPS+1];
	logic [TAPS:0]                   vld_w;

	// Result
	logic signed [ACC_W-1:0]         sum_q;
	logic signed [ACC_W:0]           t_rnd;
	logic signed [Q_W-1:0]           q_rnd;
	logic [SW-1:0]                   fsum;
	logic                            long_w;
	logic                            hist_w;
	logic                            m_vld_q;
	logic [47:0]                     m_data_q;
	logic                            m_user_q;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= arlrsf_pkg::TAPSEL_W'(1);
			for (int i = 0; i < arlrsf_pkg::NCOEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			if (reg_idx == arlrsf_pkg::REG_ACTIVE_TAPS) begin
				taps_q <= pwdata[arlrsf_pkg::TAPSEL_W-1:0];
			end else if (reg_idx inside {[arlrsf_pkg::REG_COEF_TAP0:
			                              arlrsf_pkg::REG_COEF_TAP5]}) begin
				coef_q[reg_idx - arlrsf_pkg::REG_COEF_TAP0] <= pwdata[CW-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == arlrsf_pkg::REG_ACTIVE_TAPS) begin
			prdata = 32'(taps_q);
		end else if (reg_idx inside {[arlrsf_pkg::REG_COEF_TAP0:
		                              arlrsf_pkg::REG_COEF_TAP5]}) begin
			prdata = {8'd0, coef_q[reg_idx - arlrsf_pkg::REG_COEF_TAP0]};
		end
	end

	// A lookback of zero acts as one; one above the chain length acts as the full chain.
	always_comb begin
		if (taps_q == '0) begin
			taps_eff = CNT_W'(1);
		end else if (32'(taps_q) > TAPS) begin
			taps_eff = CNT_W'(TAPS);
		end else begin
			taps_eff = CNT_W'(taps_q);
		end
	end

	// ---------------------------------------------------------------- ratio
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	arlrsf_ratio u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept),
		.bar_open  (s_axis_tdata[31:0]),
		.bar_close (s_axis_tdata[63:32]),
		.ratio_vld (ratio_vld),
		.ratio     (ratio)
	);

	// ---------------------------------------------------------------- tap chain
	assign ratio_w[0] = ratio;
	assign sum_w[0]   = '0;
	assign vld_w[0]   = sum_start_q;

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		logic signed [CW-1:0] coef_k;

		if (k < arlrsf_pkg::NCOEF) begin : g_coef
			assign coef_k = coef_q[k];
		end else begin : g_zero
			assign coef_k = '0;
		end

		arlrsf_tap_cell #(
			.ACC_W (ACC_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.push        (ratio_vld),
			.en          (CNT_W'(k) < taps_eff),
			.coef        (coef_k),
			.ratio_in    (ratio_w[k]),
			.ratio_out   (ratio_w[k+1]),
			.sum_vld_in  (vld_w[k]),
			.sum_in      (sum_w[k]),
			.sum_vld_out (vld_w[k+1]),
			.sum_out     (sum_w[k+1])
		);
	end

	// ---------------------------------------------------------------- result
	// Round to Q.20 with halves toward plus infinity, then sign-extend.
	assign t_rnd  = $signed({sum_q[ACC_W-1], sum_q}) + (ACC_W + 1)'(1 << 19);
	assign q_rnd  = Q_W'(t_rnd >>> arlrsf_pkg::FRAC_OUT);
	assign fsum   = {{(SW - Q_W){q_rnd[Q_W-1]}}, q_rnd};
	// Direction follows the exact sum, not the rounded one.
	assign long_w = !sum_q[ACC_W-1] && (sum_q != '0);
	assign hist_w = (bars_seen_q >= taps_eff);

	assign out_load = (state_q == ST_WRITE) && (!m_vld_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (vld_w[TAPS]) begin
			sum_q <= sum_w[TAPS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_start_q <= 1'b0;
			bars_seen_q <= '0;
			m_vld_q     <= 1'b0;
			m_data_q    <= '0;
			m_user_q    <= 1'b0;
		end else begin
			sum_start_q <= (state_q == ST_LOG) && ratio_vld;
			if (out_load) begin
				m_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					if (ratio_vld) begin
						state_q <= ST_SUM;
						if (32'(bars_seen_q) < TAPS) begin
							bars_seen_q <= bars_seen_q + CNT_W'(1);
						end
					end
				end
				ST_SUM: begin
					if (vld_w[TAPS]) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (out_load) begin
						m_data_q <= {7'd0, long_w, fsum};
						m_user_q <= hist_w;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid   = m_vld_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tuser[0] = m_user_q;

	// ---------------------------------------------------------------- checks
	a_one_sum_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld_w))
		else $error("more than one partial sum in the tap chain");

	a_ratio_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		ratio_vld |-> state_q == ST_LOG)
		else $error("log ratio finished outside the log phase");

	a_chain_end_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_w[TAPS] |-> state_q == ST_SUM)
		else $error("tap chain finished outside the sum phase");

	a_bar_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bars_seen_q) <= TAPS)
		else $error("bar count above chain length");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_axis_tready)
		else $error("second item accepted while one is in work");

endmodule

`default_nettype wire

// ----- tb/tb_ar_log_return_sign_forecast.sv -----
// Self-checking testbench for ar_log_return_sign_forecast: a bar driver, an output monitor
// with a built-in forecast predictor, and APB register phases. Depends on arlrsf_pkg.
`default_nettype none

module tb_ar_log_return_sign_forecast;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAPS          = arlrsf_pkg::TAPS_DEF;
	localparam int NCOEF         = arlrsf_pkg::NCOEF;
	localparam int SUM_W         = arlrsf_pkg::SUM_W;
	localparam int APB_AW        = arlrsf_pkg::APB_AW;
	localparam int APB_DW        = arlrsf_pkg::APB_DW;
	localparam int TAPSEL_W      = arlrsf_pkg::TAPSEL_W;
	localparam int COEF_W        = arlrsf_pkg::COEF_W;
	localparam int RATIO_W       = arlrsf_pkg::RATIO_W;
	localparam int LOG_FRAC      = arlrsf_pkg::LOG_FRAC;
	localparam int FRAC_OUT      = arlrsf_pkg::FRAC_OUT;
	localparam int SETTLE_CYCLES = 50;
	localparam int LONG_HOLD     = 400;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RAND_PHASES   = 8;
	// Address of an index that maps to no register.
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             go_long;
		logic             hist_ok;
	} forecast_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr  = '0;
	logic [APB_DW-1:0] pwdata = '0;
	wire logic [APB_DW-1:0] prdata;
	wire logic   pready;
	logic        s_axis_tvalid = 1'b0;
	wire logic   s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;
	wire logic   m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire logic [47:0] m_axis_tdata;
	wire logic [0:0]  m_axis_tuser;

	ar_log_return_sign_forecast #(.TAPS(TAPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Predictor state: register shadows, the ratio delay line and the bar count.
	logic [TAPSEL_W-1:0]       lookback_reg = 3'd1;
	logic signed [COEF_W-1:0]  weight_reg [NCOEF];
	logic signed [RATIO_W-1:0] lr_line [TAPS];
	int                        bar_count = 0;

	logic [63:0] bar_queue [$];
	forecast_t   fc_expected [$];

	int  mismatch_count  = 0;
	int  bars_accepted   = 0;
	int  forecasts_seen  = 0;
	int  long_forecasts  = 0;
	int  settings_used   = 0;
	int  holds_done      = 0;
	int  cycle_count     = 0;
	bit  bar_taken       = 1'b0;
	bit  hold_start      = 1'b0;

	initial begin
		for (int k = 0; k < NCOEF; k++) weight_reg[k] = '0;
		for (int k = 0; k < TAPS; k++) lr_line[k] = '0;
	end

	initial forever #4 clk = ~clk;

	// log2 of a price in Q.24: leading-one position plus fraction by repeated squaring.
	function automatic logic [63:0] price_log2_q24(input logic [31:0] price);
		logic [31:0] x;
		logic [63:0] m;
		logic [63:0] frac;
		int          e;
		int          i;
		x = (price == 32'd0) ? 32'd1 : price;
		e = 31;
		while (x[e] == 1'b0) e--;
		m = 64'(x) << (31 - e);
		frac = '0;
		for (i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (64'(e) << LOG_FRAC) | frac;
	endfunction

	function automatic logic signed [RATIO_W-1:0] bar_log_ratio(input logic [31:0] op,
			input logic [31:0] cl);
		longint          lo, lc, d;
		longint unsigned mag, r;
		longint          v;
		lo = price_log2_q24(op);
		lc = price_log2_q24(cl);
		d = lo - lc;
		mag = (d < 0) ? -d : d;
		// Round the magnitude half away from zero, then saturate to the ratio range.
		r = (mag * {32'd0, arlrsf_pkg::LN2_Q32} + (64'd1 << 35)) >> 36;
		if (d < 0)
			v = (r > 64'd8388608) ? -64'sd8388608 : -longint'(r);
		else
			v = (r > 64'd8388607) ? 64'sd8388607 : longint'(r);
		return v[RATIO_W-1:0];
	endfunction

	function automatic forecast_t forecast_bar(input logic [31:0] op, input logic [31:0] cl);
		forecast_t f;
		longint    acc, t, q;
		int        n;
		int        k;
		for (k = TAPS - 1; k > 0; k--) lr_line[k] = lr_line[k-1];
		lr_line[0] = bar_log_ratio(op, cl);
		if (bar_count < TAPS) bar_count++;
		n = lookback_reg;
		if (n == 0) n = 1;
		if (n > TAPS) n = TAPS;
		acc = 0;
		for (k = 0; k < n; k++)
			if (k < NCOEF) acc += longint'(weight_reg[k]) * longint'(lr_line[k]);
		// Arithmetic shift gives rounding with halves toward plus infinity.
		t = acc + (64'sd1 <<< 19);
		q = t >>> FRAC_OUT;
		f.sum = q[SUM_W-1:0];
		f.go_long = (acc > 0);
		f.hist_ok = (bar_count >= n);
		return f;
	endfunction

	function automatic logic [31:0] corner_price();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	function automatic logic [63:0] random_bar();
		logic [31:0] op, cl, tmp;
		longint      base, c;
		int          kind, step, sh;
		kind = $urandom_range(0, 15);
		if (kind <= 8) begin
			// Realistic bar: close drifts a little from open.
			base = longint'({32'd0, $urandom()} >> $urandom_range(0, 31));
			if (base == 0) base = 1;
			step = $urandom_range(0, 40);
			step -= 20;
			sh = $urandom_range(3, 12);
			c = base + (base >>> sh) * step + longint'($urandom_range(0, 4)) - 2;
			if (c < 1) c = 1;
			if (c > 64'sh0_FFFF_FFFF) c = 64'sh0_FFFF_FFFF;
			op = base[31:0];
			cl = c[31:0];
		end else if (kind <= 11) begin
			op = $urandom();
			cl = $urandom();
		end else if (kind == 12) begin
			op = corner_price();
			cl = corner_price();
		end else if (kind == 13) begin
			op = $urandom() >> $urandom_range(0, 31);
			cl = op;
		end else begin
			op = $urandom_range(1, 255);
			cl = $urandom() | 32'h8000_0000;
		end
		if ($urandom_range(0, 1)) begin
			tmp = op;
			op = cl;
			cl = tmp;
		end
		return {cl, op};
	endfunction

	function automatic logic [COEF_W-1:0] random_weight(input int style);
		logic [COEF_W-1:0] w;
		case (style)
			0: w = 24'($urandom());
			1: w = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
			2: begin
				w = 24'($urandom_range(0, 65535));
				if ($urandom_range(0, 1)) w = -w;
			end
			default: begin
				case ($urandom_range(0, 5))
					0: w = 24'h7F_FFFF;
					1: w = 24'h80_0000;
					2: w = 24'h00_0000;
					3: w = 24'h00_0001;
					4: w = 24'hFF_FFFF;
					default: w = 24'($urandom());
				endcase
			end
		endcase
		return w;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == arlrsf_pkg::REG_ACTIVE_TAPS)
			lookback_reg = value[TAPSEL_W-1:0];
		else if (idx inside {[arlrsf_pkg::REG_COEF_TAP0:arlrsf_pkg::REG_COEF_TAP5]})
			weight_reg[idx - arlrsf_pkg::REG_COEF_TAP0] = value[COEF_W-1:0];
	endtask

	task automatic write_weight(input int k, input logic [COEF_W-1:0] w);
		write_reg(3'(arlrsf_pkg::REG_COEF_TAP0 + k), {{(APB_DW-COEF_W){w[COEF_W-1]}}, w});
	endtask

	task automatic add_bar(input logic [31:0] op, input logic [31:0] cl);
		bar_queue = {bar_queue, {cl, op}};
	endtask

	// Holds the test sequence off until every forecast is back, then lets the block go quiet.
	task automatic settle();
		while (bar_queue.size() != 0 || fc_expected.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Bar driver: bursts of items separated by random gaps.
	int burst_left = 0;
	int gap_left   = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || bar_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (bar_queue.size() > 0) begin
				s_axis_tdata  <= bar_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: switches among four stall modes, plus one long hold-off.
	int rx_mode = 0;
	int rx_span = 0;
	int rx_tick = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		bit ready_next;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left = LONG_HOLD;
				holds_done++;
			end
			if (rx_span == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_span = $urandom_range(16, 96);
			end
			rx_span--;
			rx_tick++;
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else begin
				case (rx_mode)
					0: ready_next = 1'b1;
					1: ready_next = $urandom_range(0, 1);
					2: ready_next = ($urandom_range(0, 3) == 0);
					default: ready_next = (rx_tick % 5 != 0);
				endcase
			end
			m_axis_tready <= ready_next;
		end
	end

	// Monitor: checks each result against the oldest forecast, then predicts new bars.
	always @(posedge clk) begin
		forecast_t want;
		bar_taken = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				forecasts_seen++;
				if (fc_expected.size() == 0) begin
					mismatch_count++;
					$display("%0t unexpected result: expected none, actual sum %0d",
						$time, $signed(m_axis_tdata[SUM_W-1:0]));
				end else begin
					want = fc_expected.pop_front();
					if (want.go_long) long_forecasts++;
					if (m_axis_tdata[SUM_W-1:0] !== want.sum) begin
						mismatch_count++;
						$display("%0t forecast_sum: expected %0d actual %0d", $time,
							$signed(want.sum), $signed(m_axis_tdata[SUM_W-1:0]));
					end
					if (m_axis_tdata[SUM_W] !== want.go_long) begin
						mismatch_count++;
						$display("%0t go_long: expected %b actual %b", $time,
							want.go_long, m_axis_tdata[SUM_W]);
					end
					if (m_axis_tuser[0] !== want.hist_ok) begin
						mismatch_count++;
						$display("%0t history_ready: expected %b actual %b", $time,
							want.hist_ok, m_axis_tuser[0]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				bar_taken = 1'b1;
				bars_accepted++;
				fc_expected = {fc_expected,
					forecast_bar(s_axis_tdata[31:0], s_axis_tdata[63:32])};
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d forecasts outstanding",
				cycle_count, fc_expected.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int style;
		int count;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Full lookback with mixed weights; the first bars arrive with short history.
		write_reg(arlrsf_pkg::REG_ACTIVE_TAPS, 32'd6);
		write_weight(0, 24'h7F_FFFF);
		write_weight(1, 24'h80_0000);
		write_weight(2, 24'h10_0000);
		write_weight(3, 24'hF0_0000);
		write_weight(4, 24'h08_0000);
		write_weight(5, 24'h00_0003);
		settings_used++;
		add_bar(32'd1, 32'd1);
		add_bar(32'hFFFF_FFFF, 32'd1);
		add_bar(32'd1, 32'hFFFF_FFFF);
		add_bar(32'd0, 32'd5);
		add_bar(32'd7, 32'd0);
		add_bar(32'd0, 32'd0);
		add_bar(32'd2, 32'd1);
		add_bar(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		add_bar(32'h8000_0000, 32'h7FFF_FFFF);
		add_bar(32'd1000, 32'd2718);
		add_bar(32'h5555_5555, 32'hAAAA_AAAA);
		settle();

		// Lookback of zero acts as one; tiny sums round to zero but keep their sign.
		write_reg(arlrsf_pkg::REG_ACTIVE_TAPS, 32'd0);
		write_weight(0, 24'h00_0001);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		settings_used++;
		add_bar(32'd1000001, 32'd1000000);
		add_bar(32'd1000000, 32'd1000001);
		settle();
		// A weight of one half puts the sum exactly on a rounding tie.
		write_weight(0, 24'h08_0000);
		settings_used++;
		add_bar(32'd1000001, 32'd1000000);
		add_bar(32'd1000000, 32'd1000001);
		settle();
		// Lookback above the chain length acts as the full chain.
		write_reg(arlrsf_pkg::REG_ACTIVE_TAPS, 32'd7);
		settings_used++;
		add_bar(32'd3000, 32'd1000);
		add_bar(32'd1000, 32'd3000);
		add_bar(32'hFFFF_FFFF, 32'd1);
		settle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			style = p % 4;
			write_reg(arlrsf_pkg::REG_ACTIVE_TAPS,
				(p == 0) ? 32'd6 : 32'($urandom_range(0, 7)));
			for (int k = 0; k < NCOEF; k++) write_weight(k, random_weight(style));
			settings_used++;
			if (p == 2) hold_start = 1'b1;
			count = $urandom_range(80, 100);
			for (int i = 0; i < count; i++) bar_queue = {bar_queue, random_bar()};
			settle();
		end

		$display("Covered %0d bars under %0d register settings, %0d long output hold-offs;",
			bars_accepted, settings_used, holds_done);
		$display("%0d forecasts checked, %0d of them long.", forecasts_seen, long_forecasts);
		if (mismatch_count == 0 && fc_expected.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- ar_log_return_sign_forecast.f -----
rtl/arlrsf_pkg.sv
rtl/arlrsf_log2.sv
rtl/arlrsf_ratio.sv
rtl/arlrsf_tap_cell.sv
rtl/ar_log_return_sign_forecast.sv
tb/tb_ar_log_return_sign_forecast.sv
